@@ design/sia_pkg.sv @@
// shared types and constants for the 16-lane signed 8-bit vector alu
// used by the interfaces, the lane, the output stage and the top level
// no dependencies
package sia_pkg;

	// number of active lanes and the fixed vector geometry
	localparam int LANE_COUNT = 16;
	localparam int VEC_LANES = 16;
	localparam int HALF_LANES = 8;
	localparam int BYTE_W = 8;
	localparam int HALF_W = 64;
	localparam int OP_W = 5;
	localparam int SHIFT_W = 3;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [HALF_W-1:0] half_t;
	typedef logic [OP_W-1:0] op_t;

	// operation codes
	localparam op_t OP_SPLAT  = 5'd0;
	localparam op_t OP_NEG    = 5'd1;
	localparam op_t OP_ADD    = 5'd2;
	localparam op_t OP_SUB    = 5'd3;
	localparam op_t OP_MUL    = 5'd4;
	localparam op_t OP_ADDS   = 5'd5;
	localparam op_t OP_SUBS   = 5'd6;
	localparam op_t OP_MIN    = 5'd7;
	localparam op_t OP_MAX    = 5'd8;
	localparam op_t OP_LT     = 5'd9;
	localparam op_t OP_LE     = 5'd10;
	localparam op_t OP_EQ     = 5'd11;
	localparam op_t OP_NE     = 5'd12;
	localparam op_t OP_GT     = 5'd13;
	localparam op_t OP_GE     = 5'd14;
	localparam op_t OP_SHL    = 5'd15;
	localparam op_t OP_SRA    = 5'd16;
	localparam op_t OP_SELECT = 5'd17;

	// byte constants for saturation and comparison masks
	localparam byte_t BYTE_ONES = 8'hFF;
	localparam byte_t BYTE_ZERO = 8'h00;
	localparam byte_t SAT_MAX   = 8'h7F;
	localparam byte_t SAT_MIN   = 8'h80;

	// control shared by every lane for one item
	typedef struct packed {
		op_t                op;
		logic [SHIFT_W-1:0] shift;
		byte_t              scalar;
	} lane_ctrl_t;

	// one merged result vector
	typedef struct packed {
		half_t result_high;
		half_t result_low;
	} result_t;

endpackage

@@ design/sia_if.sv @@
// valid/ready channel interfaces for operand items and result items
// depends on sia_pkg

// operand channel
interface sia_req_if;
	logic                valid;
	logic                ready;
	sia_pkg::op_t        op;
	sia_pkg::half_t      a_low;
	sia_pkg::half_t      a_high;
	sia_pkg::half_t      b_low;
	sia_pkg::half_t      b_high;
	sia_pkg::half_t      c_low;
	sia_pkg::half_t      c_high;
	logic [7:0]          shift_count;
	logic signed [7:0]   scalar;

	modport source (output valid, op, a_low, a_high, b_low, b_high, c_low, c_high,
		shift_count, scalar, input ready);
	modport sink (input valid, op, a_low, a_high, b_low, b_high, c_low, c_high,
		shift_count, scalar, output ready);
endinterface

// result channel
interface sia_rsp_if;
	logic           valid;
	logic           ready;
	sia_pkg::half_t result_low;
	sia_pkg::half_t result_high;

	modport source (output valid, result_low, result_high, input ready);
	modport sink (input valid, result_low, result_high, output ready);
endinterface

@@ design/sia_lane.sv @@
// one signed 8-bit alu lane: arithmetic, saturation, compare, shift, select
// depends on sia_pkg
module sia_lane (
	input  sia_pkg::lane_ctrl_t ctrl,
	input  sia_pkg::byte_t      a,
	input  sia_pkg::byte_t      b,
	input  sia_pkg::byte_t      c,
	output sia_pkg::byte_t      r
);

	logic [8:0]     sum9;
	logic [8:0]     diff9;
	logic [15:0]    prod;
	logic           lt;
	logic           eq;
	sia_pkg::byte_t adds_r;
	sia_pkg::byte_t subs_r;
	sia_pkg::byte_t sra_r;

	// widened sums for overflow detection
	assign sum9  = {a[7], a} + {b[7], b};
	assign diff9 = {a[7], a} - {b[7], b};
	assign prod  = a * b;
	assign lt    = $signed(a) < $signed(b);
	assign eq    = a == b;
	assign sra_r = sia_pkg::byte_t'($signed(a) >>> ctrl.shift);

	// clamp when the two top bits disagree
	always_comb begin
		if (sum9[8] != sum9[7]) begin
			adds_r = sum9[8] ? sia_pkg::SAT_MIN : sia_pkg::SAT_MAX;
		end else begin
			adds_r = sum9[7:0];
		end
		if (diff9[8] != diff9[7]) begin
			subs_r = diff9[8] ? sia_pkg::SAT_MIN : sia_pkg::SAT_MAX;
		end else begin
			subs_r = diff9[7:0];
		end
	end

	// operation select; unused codes give zero
	always_comb begin
		unique case (ctrl.op)
			sia_pkg::OP_SPLAT:  r = ctrl.scalar;
			sia_pkg::OP_NEG:    r = sia_pkg::BYTE_ZERO - a;
			sia_pkg::OP_ADD:    r = sum9[7:0];
			sia_pkg::OP_SUB:    r = diff9[7:0];
			sia_pkg::OP_MUL:    r = prod[7:0];
			sia_pkg::OP_ADDS:   r = adds_r;
			sia_pkg::OP_SUBS:   r = subs_r;
			sia_pkg::OP_MIN:    r = lt ? a : b;
			sia_pkg::OP_MAX:    r = (!lt && !eq) ? a : b;
			sia_pkg::OP_LT:     r = lt ? sia_pkg::BYTE_ONES : sia_pkg::BYTE_ZERO;
			sia_pkg::OP_LE:     r = (lt || eq) ? sia_pkg::BYTE_ONES : sia_pkg::BYTE_ZERO;
			sia_pkg::OP_EQ:     r = eq ? sia_pkg::BYTE_ONES : sia_pkg::BYTE_ZERO;
			sia_pkg::OP_NE:     r = eq ? sia_pkg::BYTE_ZERO : sia_pkg::BYTE_ONES;
			sia_pkg::OP_GT:     r = (!lt && !eq) ? sia_pkg::BYTE_ONES : sia_pkg::BYTE_ZERO;
			sia_pkg::OP_GE:     r = lt ? sia_pkg::BYTE_ZERO : sia_pkg::BYTE_ONES;
			sia_pkg::OP_SHL:    r = a << ctrl.shift;
			sia_pkg::OP_SRA:    r = sra_r;
			sia_pkg::OP_SELECT: r = (a & b) | (~a & c);
			default:            r = sia_pkg::BYTE_ZERO;
		endcase
	end

endmodule

@@ design/sia_merge.sv @@
// merging stage: gathers the lane results into one vector held in an
// output register backed by a one-entry skid register
// depends on sia_pkg and sia_rsp_if
module sia_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sia_pkg::byte_t [sia_pkg::VEC_LANES-1:0] lane_r,
	input  logic                              lane_valid,
	output logic                              lane_ready,
	sia_rsp_if.source                         rsp
);

	sia_pkg::result_t merged;
	sia_pkg::result_t data_s1;
	sia_pkg::result_t skid_q;
	logic             valid_s1;
	logic             skid_valid_q;
	logic             in_fire;
	logic             out_fire;

	// pack lanes: lane 0 in the low byte of the low half
	always_comb begin
		for (int i = 0; i < sia_pkg::HALF_LANES; i++) begin
			merged.result_low[i*sia_pkg::BYTE_W +: sia_pkg::BYTE_W] = lane_r[i];
			merged.result_high[i*sia_pkg::BYTE_W +: sia_pkg::BYTE_W] =
				lane_r[i + sia_pkg::HALF_LANES];
		end
	end

	assign lane_ready = !skid_valid_q;
	assign in_fire    = lane_valid && lane_ready;
	assign out_fire   = valid_s1 && rsp.ready;

	// output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!valid_s1 || out_fire) begin
				valid_s1     <= skid_valid_q || in_fire;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!valid_s1 || out_fire) begin
			data_s1 <= skid_valid_q ? skid_q : merged;
		end else if (in_fire) begin
			skid_q <= merged;
		end
	end

	assign rsp.valid       = valid_s1;
	assign rsp.result_low  = data_s1.result_low;
	assign rsp.result_high = data_s1.result_high;

	// skid holds an item only behind a waiting output item
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> valid_s1)
		else $error("skid register full while output register empty");

	// an item arriving against a stalled output lands in the skid register
	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && valid_s1 && !rsp.ready |=> skid_valid_q && skid_q == $past(merged))
		else $error("stalled item not captured in skid register");

	// a drained skid item moves to the output register
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_fire |=> valid_s1 && data_s1 == $past(skid_q))
		else $error("skid item lost on drain");

	// output empties when taken with nothing behind it
	a_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !skid_valid_q && !in_fire |=> !valid_s1)
		else $error("output valid without a pending item");

endmodule

@@ design/simd_int8x16_alu_top.sv @@
// results are registered in the output register, or in the skid register while the output stalls
// throughput: one item per cycle while the skid register is empty; all lanes compute in the cycle of acceptance
// a one-entry skid register lets one more item in while the output stalls
// reset clears the output and skid valid flags only; the payload registers are not reset
// depends on sia_pkg, sia_if, sia_lane and sia_merge
module simd_int8x16_alu_top (
	input  logic       clk,
	input  logic       arst_n,
	sia_req_if.sink    req,
	sia_rsp_if.source  rsp
);

	sia_pkg::lane_ctrl_t                       ctrl;
	sia_pkg::byte_t [sia_pkg::VEC_LANES-1:0]   lane_r;
	logic [2*sia_pkg::HALF_W-1:0]              vec_a;
	logic [2*sia_pkg::HALF_W-1:0]              vec_b;
	logic [2*sia_pkg::HALF_W-1:0]              vec_c;

	// controls broadcast to every lane
	assign ctrl.op     = req.op;
	assign ctrl.shift  = req.shift_count[sia_pkg::SHIFT_W-1:0];
	assign ctrl.scalar = req.scalar;

	assign vec_a = {req.a_high, req.a_low};
	assign vec_b = {req.b_high, req.b_low};
	assign vec_c = {req.c_high, req.c_low};

	// lane array; lanes beyond the active count read zero
	for (genvar i = 0; i < sia_pkg::VEC_LANES; i++) begin : g_lane
		if (i < sia_pkg::LANE_COUNT) begin : g_on
			sia_lane u_lane (
				.ctrl (ctrl),
				.a    (vec_a[i*sia_pkg::BYTE_W +: sia_pkg::BYTE_W]),
				.b    (vec_b[i*sia_pkg::BYTE_W +: sia_pkg::BYTE_W]),
				.c    (vec_c[i*sia_pkg::BYTE_W +: sia_pkg::BYTE_W]),
				.r    (lane_r[i])
			);
		end else begin : g_off
			assign lane_r[i] = sia_pkg::BYTE_ZERO;
		end
	end

	// merge and output register
	sia_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_r     (lane_r),
		.lane_valid (req.valid),
		.lane_ready (req.ready),
		.rsp        (rsp)
	);

endmodule
